@@ hdl/rd_pkg.sv @@
// ----------------------------------------------------------------------------
// rd_pkg
// shared types and constants for the reversible deque
// ----------------------------------------------------------------------------
package rd_pkg;

    localparam int DEPTH_DEF      = 1024;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int VALUE_W        = 32;
    localparam int ACTION_W       = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INS_HEAD = 2'd0,
        ACT_INS_TAIL = 2'd1,
        ACT_REM_HEAD = 2'd2,
        ACT_REVERSE  = 2'd3
    } action_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_DONE = 1'b1
    } ctrl_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic exec;   // run one action on the current inputs
    } ctrl_cmd_t;

endpackage

@@ hdl/reversible_deque.sv @@
// ----------------------------------------------------------------------------
// reversible_deque
// bounded double-ended queue in a ring buffer with constant-time reversal
// ----------------------------------------------------------------------------
// the result is strobed on done in the cycle after the start transfer
// a new action is not accepted while the controller is in its result state
// reset: asynchronous, clears head pointer, count, direction flag and the fsm
// the element memory is not cleared; entries are read only after a write
// the receiver cannot stall: each result is valid for exactly one cycle
module reversible_deque
#(
    parameter int DEPTH      = rd_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = rd_pkg::DATA_WIDTH_DEF,
    parameter int CW         = $clog2(DEPTH + 1)
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // command side: transfer when start is high and busy is low
    input  logic                              start,
    output logic                              busy,
    input  logic [rd_pkg::ACTION_W-1:0]       action,
    input  logic signed [rd_pkg::VALUE_W-1:0] value,
    // result side: one transfer per action, marked by done
    output logic                              done,
    output logic                              ok,
    output logic signed [rd_pkg::VALUE_W-1:0] removed_value,
    output logic [CW-1:0]                     count
);

    rd_pkg::ctrl_cmd_t cmd;

    // controller sequences accept and result cycles
    rd_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // datapath holds the ring buffer and its pointers; the direction flag
    // swaps which end of the occupied span acts as the head
    rd_datapath
    #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .CW         (CW)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .action        (action),
        .value         (value),
        .ok            (ok),
        .removed_value (removed_value),
        .count         (count)
    );

endmodule

@@ hdl/rd_ctrl.sv @@
// ----------------------------------------------------------------------------
// rd_ctrl
// controller: accepts one action, then presents its result for one cycle
// ----------------------------------------------------------------------------
module rd_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    output rd_pkg::ctrl_cmd_t cmd
);

    rd_pkg::ctrl_state_t state_reg;
    rd_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        busy       = 1'b0;
        done       = 1'b0;
        cmd.exec   = 1'b0;
        case (state_reg)
            rd_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.exec   = 1'b1;
                    state_next = rd_pkg::ST_DONE;
                end
            end
            rd_pkg::ST_DONE:
            begin
                // result registers and memory read data are valid here
                busy       = 1'b1;
                done       = 1'b1;
                state_next = rd_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/rd_datapath.sv @@
// ----------------------------------------------------------------------------
// rd_datapath
// ring buffer storage, head pointer, element count and direction flag
// ----------------------------------------------------------------------------
module rd_datapath
#(
    parameter int DEPTH      = rd_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = rd_pkg::DATA_WIDTH_DEF,
    parameter int CW         = $clog2(DEPTH + 1)
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  rd_pkg::ctrl_cmd_t                cmd,
    input  logic [rd_pkg::ACTION_W-1:0]      action,
    input  logic signed [rd_pkg::VALUE_W-1:0] value,
    output logic                             ok,
    output logic signed [rd_pkg::VALUE_W-1:0] removed_value,
    output logic [CW-1:0]                    count
);

    localparam int AW = $clog2(DEPTH);
    localparam int SW = CW + 1;
    localparam int EW = DATA_WIDTH + rd_pkg::VALUE_W;

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [AW-1:0]         front_reg;
    logic [AW-1:0]         front_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  rev_reg;
    logic                  rev_next;
    logic                  ok_reg;
    logic                  ok_next;
    logic                  rm_reg;
    logic                  rm_next;
    logic [DATA_WIDTH-1:0] rd_reg;

    logic                  full;
    logic                  empty;
    logic                  at_low;
    logic [AW-1:0]         front_dec;
    logic [AW-1:0]         front_inc;
    logic [SW-1:0]         end_sum;
    logic [SW-1:0]         last_sum;
    logic [SW-1:0]         end_wrap;
    logic [SW-1:0]         last_wrap;
    logic                  mem_we;
    logic                  mem_re;
    logic [AW-1:0]         mem_addr;
    logic [EW-1:0]         val_ext;
    logic [EW-1:0]         rd_ext;

    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);
    assign at_low = (action == rd_pkg::ACT_INS_HEAD) != rev_reg;

    assign front_dec = (front_reg == '0) ? AW'(DEPTH - 1) : front_reg - AW'(1);
    assign front_inc = (front_reg == AW'(DEPTH - 1)) ? '0 : front_reg + AW'(1);

    // slot past the tail and slot of the tail, both below twice the depth when not empty
    assign end_sum   = SW'(front_reg) + SW'(count_reg);
    assign last_sum  = end_sum - SW'(1);
    assign end_wrap  = (end_sum >= SW'(DEPTH)) ? end_sum - SW'(DEPTH) : end_sum;
    assign last_wrap = (last_sum >= SW'(DEPTH)) ? last_sum - SW'(DEPTH) : last_sum;

    assign val_ext = EW'($unsigned(value));

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        rev_next   = rev_reg;
        ok_next    = ok_reg;
        rm_next    = rm_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = front_reg;
        if (cmd.exec)
        begin
            ok_next = 1'b0;
            rm_next = 1'b0;
            case (action)
                rd_pkg::ACT_INS_HEAD,
                rd_pkg::ACT_INS_TAIL:
                begin
                    if (!full)
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                        ok_next    = 1'b1;
                        if (at_low)
                        begin
                            front_next = front_dec;
                            mem_addr   = front_dec;
                        end
                        else
                        begin
                            mem_addr = end_wrap[AW-1:0];
                        end
                    end
                end
                rd_pkg::ACT_REM_HEAD:
                begin
                    if (!empty)
                    begin
                        mem_re     = 1'b1;
                        count_next = count_reg - CW'(1);
                        ok_next    = 1'b1;
                        rm_next    = 1'b1;
                        if (!rev_reg)
                        begin
                            front_next = front_inc;
                        end
                        else
                        begin
                            mem_addr = last_wrap[AW-1:0];
                        end
                    end
                end
                rd_pkg::ACT_REVERSE:
                begin
                    if (!empty)
                    begin
                        rev_next = !rev_reg;
                        ok_next  = 1'b1;
                    end
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
            rev_reg   <= 1'b0;
            ok_reg    <= 1'b0;
            rm_reg    <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            rev_reg   <= rev_next;
            ok_reg    <= ok_next;
            rm_reg    <= rm_next;
        end
    end

    // single port storage, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= val_ext[DATA_WIDTH-1:0];
        end
        if (mem_re)
        begin
            rd_reg <= mem[mem_addr];
        end
    end

    assign rd_ext        = EW'(rd_reg);
    assign ok            = ok_reg;
    assign count         = count_reg;
    assign removed_value = rm_reg ? $signed(rd_ext[rd_pkg::VALUE_W-1:0]) : '0;

endmodule

@@ tb/tb_reversible_deque.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_reversible_deque
// self-checking bench for the reversible deque: actions go in through the
// start/busy command port, a local deque model predicts every result, and
// each done strobe is checked field by field against the oldest prediction
// ----------------------------------------------------------------------------
module tb_reversible_deque;

    localparam int DQ_DEPTH      = rd_pkg::DEPTH_DEF;
    localparam int IDX_W         = $clog2(DQ_DEPTH);
    localparam int CNT_W         = $clog2(DQ_DEPTH + 1);
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic                       ok;
        logic [rd_pkg::VALUE_W-1:0] removed;
        logic [CNT_W-1:0]           cnt;
    } deque_result_t;

    // dut signals
    logic                              clk;
    logic                              rst_n;
    logic                              start;
    logic                              busy;
    logic [rd_pkg::ACTION_W-1:0]       action;
    logic signed [rd_pkg::VALUE_W-1:0] value;
    logic                              done;
    logic                              ok;
    logic signed [rd_pkg::VALUE_W-1:0] removed_value;
    logic [CNT_W-1:0]                  count;

    // local deque model
    logic [rd_pkg::VALUE_W-1:0] model_slots [DQ_DEPTH];
    logic [IDX_W-1:0]           model_front;
    logic [CNT_W-1:0]           model_held;
    logic                       model_flipped;

    // predictions waiting for their done strobe, oldest first
    deque_result_t pending_results[$];
    deque_result_t check_res;

    // run bookkeeping
    int  errors      = 0;
    int  cycle_cnt   = 0;
    int  n_transfers = 0;
    int  n_inserts   = 0;
    int  n_removes   = 0;
    int  n_reverses  = 0;
    int  n_refused   = 0;
    int  n_full_hits = 0;
    int  peak_held   = 0;
    bit  idle_enable = 1'b1;

    reversible_deque uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .value         (value),
        .done          (done),
        .ok            (ok),
        .removed_value (removed_value),
        .count         (count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // model of one action; updates the local deque and returns its result
    // ------------------------------------------------------------------------
    function automatic deque_result_t apply_action(
        input logic [rd_pkg::ACTION_W-1:0] act,
        input logic [rd_pkg::VALUE_W-1:0]  val);
        deque_result_t    res;
        logic             at_low;
        logic [IDX_W-1:0] slot;
        res.ok      = 1'b0;
        res.removed = '0;
        case (act)
            rd_pkg::ACT_INS_HEAD, rd_pkg::ACT_INS_TAIL:
            begin
                if (model_held < DQ_DEPTH)
                begin
                    // head insert in normal order or tail insert when flipped
                    // grows the low end of the occupied span
                    at_low = (act == rd_pkg::ACT_INS_HEAD) ^ model_flipped;
                    if (at_low)
                    begin
                        model_front = model_front - 1'b1;
                        model_slots[model_front] = val;
                    end
                    else
                    begin
                        slot = model_front + model_held[IDX_W-1:0];
                        model_slots[slot] = val;
                    end
                    model_held = model_held + 1'b1;
                    res.ok     = 1'b1;
                end
            end
            rd_pkg::ACT_REM_HEAD:
            begin
                if (model_held != 0)
                begin
                    if (!model_flipped)
                    begin
                        res.removed = model_slots[model_front];
                        model_front = model_front + 1'b1;
                    end
                    else
                    begin
                        slot        = model_front + model_held[IDX_W-1:0] - 1'b1;
                        res.removed = model_slots[slot];
                    end
                    model_held = model_held - 1'b1;
                    res.ok     = 1'b1;
                end
            end
            default:
            begin
                // reverse only flips the direction, and only on a non-empty deque
                if (model_held != 0)
                begin
                    model_flipped = ~model_flipped;
                    res.ok        = 1'b1;
                end
            end
        endcase
        res.cnt = model_held;
        return res;
    endfunction

    function automatic logic [rd_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '1;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // ins_pct percent inserts, rem_pct percent removes, the rest reverses
    function automatic rd_pkg::action_t pick_action(input int ins_pct, input int rem_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < ins_pct)
            return $urandom_range(0, 1) ? rd_pkg::ACT_INS_TAIL : rd_pkg::ACT_INS_HEAD;
        else if (roll < ins_pct + rem_pct)
            return rd_pkg::ACT_REM_HEAD;
        else
            return rd_pkg::ACT_REVERSE;
    endfunction

    // ------------------------------------------------------------------------
    // one command transfer; start stays high so back-to-back sends are seamless
    // ------------------------------------------------------------------------
    task automatic send_action(input rd_pkg::action_t act,
                               input logic [rd_pkg::VALUE_W-1:0] val);
        deque_result_t exp_res;
        start  <= 1'b1;
        action <= act;
        value  <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // transfer taken at this edge
        exp_res = apply_action(act, val);
        pending_results.push_back(exp_res);
        n_transfers++;
        if (!exp_res.ok)
        begin
            n_refused++;
            if (act == rd_pkg::ACT_INS_HEAD || act == rd_pkg::ACT_INS_TAIL)
                n_full_hits++;
        end
        else if (act == rd_pkg::ACT_REM_HEAD)
            n_removes++;
        else if (act == rd_pkg::ACT_REVERSE)
            n_reverses++;
        else
            n_inserts++;
        if (model_held > peak_held)
            peak_held = model_held;
    endtask

    task automatic maybe_idle();
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------------
    task automatic test_empty_refusals();
        // remove and reverse on an empty deque are refused; value is ignored
        send_action(rd_pkg::ACT_REM_HEAD, 32'hdead_beef);
        maybe_idle();
        send_action(rd_pkg::ACT_REVERSE, 32'h1234_5678);
        maybe_idle();
    endtask

    task automatic test_edge_values();
        send_action(rd_pkg::ACT_INS_HEAD, 32'h7fff_ffff);
        maybe_idle();
        send_action(rd_pkg::ACT_INS_TAIL, 32'h8000_0000);
        maybe_idle();
        send_action(rd_pkg::ACT_INS_HEAD, 32'hffff_ffff);
        maybe_idle();
        send_action(rd_pkg::ACT_INS_TAIL, 32'h0000_0000);
        maybe_idle();
        send_action(rd_pkg::ACT_INS_HEAD, 32'h0000_0001);
        maybe_idle();
        send_action(rd_pkg::ACT_REM_HEAD, 32'hffff_ffff);
        maybe_idle();
        send_action(rd_pkg::ACT_REM_HEAD, 32'h0000_0000);
        maybe_idle();
    endtask

    task automatic test_reverse_order();
        // flipped: head insert lands at the high end, remove takes from it
        send_action(rd_pkg::ACT_REVERSE, 32'hffff_ffff);
        maybe_idle();
        send_action(rd_pkg::ACT_INS_HEAD, 32'haaaa_aaaa);
        maybe_idle();
        send_action(rd_pkg::ACT_INS_TAIL, 32'h5555_5555);
        maybe_idle();
        send_action(rd_pkg::ACT_REM_HEAD, 32'h0f0f_0f0f);
        maybe_idle();
        send_action(rd_pkg::ACT_REVERSE, 32'h0);
        maybe_idle();
        send_action(rd_pkg::ACT_REM_HEAD, 32'h0);
        maybe_idle();
        send_action(rd_pkg::ACT_REVERSE, 32'h0);
        maybe_idle();
        // drain to empty, then hit the empty refusals with the flag set
        while (model_held != 0)
        begin
            send_action(rd_pkg::ACT_REM_HEAD, 32'h0);
            maybe_idle();
        end
        send_action(rd_pkg::ACT_REM_HEAD, 32'h7fff_ffff);
        maybe_idle();
        send_action(rd_pkg::ACT_REVERSE, 32'h8000_0000);
        maybe_idle();
    endtask

    // ------------------------------------------------------------------------
    // random tests
    // ------------------------------------------------------------------------
    task automatic test_mixed_traffic(input int n_items);
        for (int i = 0; i < n_items; i++)
        begin
            // gaps allowed in the first 50 items, then alternating per stretch of 50
            idle_enable = ((i / 50) % 2 == 0);
            send_action(pick_action(45, 40), pick_value());
            maybe_idle();
        end
        idle_enable = 1'b1;
    endtask

    task automatic test_fill_to_full();
        while (model_held != DQ_DEPTH)
        begin
            send_action(pick_action(98, 1), pick_value());
            maybe_idle();
        end
        // hover at full: refused inserts, reverses and removes with refills
        repeat (20)
        begin
            send_action(pick_action(60, 25), pick_value());
            maybe_idle();
        end
    endtask

    task automatic test_drain(input int n_items);
        for (int i = 0; i < n_items; i++)
        begin
            send_action(pick_action(20, 70), pick_value());
            maybe_idle();
        end
    endtask

    task automatic test_back_to_back(input int n_items);
        idle_enable = 1'b0;
        for (int i = 0; i < n_items; i++)
            send_action(pick_action(45, 40), pick_value());
    endtask

    // ------------------------------------------------------------------------
    // result checker: every done strobe takes the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no transfer pending: ok=%0b removed_value=%0d count=%0d",
                       ok, removed_value, count);
                errors++;
            end
            else
            begin
                check_res = pending_results.pop_front();
                if (ok !== check_res.ok)
                begin
                    $error("ok mismatch: expected %0b, actual %0b", check_res.ok, ok);
                    errors++;
                end
                if (removed_value !== check_res.removed)
                begin
                    $error("removed_value mismatch: expected %0d, actual %0d",
                           $signed(check_res.removed), removed_value);
                    errors++;
                end
                if (count !== check_res.cnt)
                begin
                    $error("count mismatch: expected %0d, actual %0d", check_res.cnt, count);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        action        = rd_pkg::ACT_INS_HEAD;
        value         = '0;
        model_front   = '0;
        model_held    = '0;
        model_flipped = 1'b0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_refusals();
        test_edge_values();
        test_reverse_order();
        test_mixed_traffic(30);
        test_fill_to_full();
        test_drain(30);
        test_back_to_back(30);

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        $display("covered %0d transfers: %0d inserts, %0d removes, %0d reverses",
                 n_transfers, n_inserts, n_removes, n_reverses);
        $display("%0d refused (%0d on a full deque), peak occupancy %0d of %0d",
                 n_refused, n_full_hits, peak_held, DQ_DEPTH);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ files.f @@
hdl/rd_pkg.sv
hdl/rd_ctrl.sv
hdl/rd_datapath.sv
hdl/reversible_deque.sv
tb/tb_reversible_deque.sv
